/* rtl/kmpoc_pkg.sv */
// shared constants for the pattern occurrence counter: sizes, command and status codes
// no dependencies
`default_nettype none

package kmpoc_pkg;

	// pattern store depth and count width
	localparam int MAX_PATTERN = 256;
	localparam int COUNT_BITS  = 32;

	// derived widths: index into the stores and a length that can reach the depth
	localparam int IDX_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// field widths of the stream items
	localparam int CMD_W    = 2;
	localparam int SYM_W    = 8;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// saturation limit of the occurrence count
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage

`default_nettype wire

/* rtl/kmp_occurrence_counter.sv */
// pattern occurrence counter: prefix-function matcher over a byte stream
// pattern and failure entries held in two synchronous memories; uses kmpoc_pkg
//
// usage
//   slave channel carries commands: clear, append a pattern byte, or a text byte
//   master channel returns exactly one result per command: match flag,
//   running occurrence total and a status code
//   clear, dropped appends, the first append, text with an empty pattern and
//   unused codes go from the idle state straight to the emit state, which
//   loads the output register once it is free; other appends and text bytes
//   pass through the walk state first, following failure links, each one a
//   memory read whose registered read data addresses the next read; links
//   average at most one per text byte
//   one command is processed at a time; the next one is taken while a result
//   still waits in the output register, and processing stalls before writing
//   the output register until the receiver takes the earlier result
//   reset empties the pattern and zeroes the partial match and the count; the
//   memories are not cleared, only entries written since the last clear are read
//   the count saturates at its maximum
`default_nettype none

module kmp_occurrence_counter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] symbol
	input  wire logic [1:0]  s_tuser,  // [1:0] cmd
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] match_total
	output logic [2:0]       m_tuser   // [0] match, [2:1] status
);
	import kmpoc_pkg::*;

	// control states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;

	// pattern and failure memories
	logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
	logic [LEN_W-1:0] fail_mem [MAX_PATTERN];
	logic [SYM_W-1:0] pat_rd_q;
	logic [LEN_W-1:0] fail_rd_q;
	logic [IDX_W-1:0] pat_raddr;
	logic [IDX_W-1:0] fail_raddr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [SYM_W-1:0] wr_sym;
	logic [LEN_W-1:0] wr_fail;

	// scalar state
	logic [LEN_W-1:0]      pat_len_q;
	logic [LEN_W-1:0]      build_prefix_q;
	logic [LEN_W-1:0]      matched_q;
	logic [COUNT_BITS-1:0] count_q;

	// current command and walk position
	logic [CMD_W-1:0] cmd_q;
	logic [SYM_W-1:0] sym_q;
	logic [LEN_W-1:0] j_q;

	// pending result
	logic                res_match_q;
	logic [STATUS_W-1:0] res_status_q;

	// output register
	logic                m_tvalid_q;
	logic [TOTAL_W-1:0]  total_out_q;
	logic                match_out_q;
	logic [STATUS_W-1:0] status_out_q;

	logic             s_xfer;
	logic             out_free;
	logic             sym_eq;
	logic [LEN_W-1:0] j_next;
	logic [LEN_W-1:0] j_start;
	logic [LEN_W-1:0] walk_j;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// comparison against the stored byte at the current walk position
	assign sym_eq = (sym_q == pat_rd_q);
	assign j_next = j_q + LEN_W'(1);

	// starting point of a walk: last failure entry for appends, partial match for text
	assign j_start = (s_tuser == CMD_APPEND) ? build_prefix_q : matched_q;

	// read addresses: start of a walk, or the failure link just read
	always_comb begin
		walk_j = (state_q == ST_EVAL) ? fail_rd_q : j_start;
		pat_raddr  = walk_j[IDX_W-1:0];
		fail_raddr = IDX_W'(walk_j - LEN_W'(1));
	end

	// write port: first pattern byte at transfer, later ones at the end of the walk
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pat_len_q[IDX_W-1:0];
		wr_sym  = sym_q;
		wr_fail = '0;
		if (s_xfer && s_tuser == CMD_APPEND && pat_len_q == '0) begin
			wr_en  = 1'b1;
			wr_sym = s_tdata;
		end else if (state_q == ST_EVAL && cmd_q == CMD_APPEND
		             && (sym_eq || j_q == '0)) begin
			wr_en   = 1'b1;
			wr_fail = sym_eq ? j_next : '0;
		end
	end

	// memories: synchronous read, one write port each
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_mem[wr_addr]  <= wr_sym;
			fail_mem[wr_addr] <= wr_fail;
		end
		pat_rd_q  <= pat_mem[pat_raddr];
		fail_rd_q <= fail_mem[fail_raddr];
	end

	// command sequencing and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pat_len_q      <= '0;
			build_prefix_q <= '0;
			matched_q      <= '0;
			count_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						state_q <= ST_EMIT;
						case (s_tuser)
							CMD_CLEAR: begin
								pat_len_q      <= '0;
								build_prefix_q <= '0;
								matched_q      <= '0;
								count_q        <= '0;
							end
							CMD_APPEND: begin
								if (pat_len_q == LEN_W'(MAX_PATTERN)) begin
									state_q <= ST_EMIT;
								end else if (pat_len_q == '0) begin
									build_prefix_q <= '0;
									pat_len_q      <= LEN_W'(1);
								end else begin
									state_q <= ST_EVAL;
								end
							end
							CMD_TEXT: begin
								if (pat_len_q != '0) begin
									state_q <= ST_EVAL;
								end
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_EVAL: begin
					if (sym_eq || j_q == '0) begin
						state_q <= ST_EMIT;
						if (cmd_q == CMD_APPEND) begin
							build_prefix_q <= sym_eq ? j_next : '0;
							pat_len_q      <= pat_len_q + LEN_W'(1);
						end else if (sym_eq && j_next == pat_len_q) begin
							// whole pattern seen: fall back by the last failure entry
							matched_q <= build_prefix_q;
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + COUNT_BITS'(1);
							end
						end else begin
							matched_q <= sym_eq ? j_next : '0;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command, walk position and pending result
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cmd_q        <= s_tuser;
			sym_q        <= s_tdata;
			j_q          <= j_start;
			res_match_q  <= 1'b0;
			res_status_q <= STATUS_OK;
			if (s_tuser == CMD_APPEND && pat_len_q == LEN_W'(MAX_PATTERN)) begin
				res_status_q <= STATUS_FULL;
			end else if (s_tuser == CMD_TEXT && pat_len_q == '0) begin
				res_status_q <= STATUS_EMPTY;
			end
		end else if (state_q == ST_EVAL) begin
			if (!sym_eq && j_q != '0) begin
				j_q <= fail_rd_q;
			end else if (cmd_q == CMD_TEXT && sym_eq && j_next == pat_len_q) begin
				res_match_q <= 1'b1;
			end
		end
	end

	// output register: loaded when the result is ready and the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			total_out_q  <= TOTAL_W'(count_q);
			match_out_q  <= res_match_q;
			status_out_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = total_out_q;
	assign m_tuser  = {status_out_q, match_out_q};

endmodule

`default_nettype wire

/* tb/kmpoc_checker.sv */
// result checker for the pattern occurrence counter: follows both stream channels,
// predicts each result from its own copy of pattern, failure table and count
// depends on kmpoc_pkg; reports a mismatch count and the number of results still due

module kmpoc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] symbol
	input  logic [1:0]  s_tuser,     // [1:0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,     // [31:0] match_total
	input  logic [2:0]  m_tuser,     // [0] match, [2:1] status
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import kmpoc_pkg::*;

	typedef struct packed {
		logic                hit;
		logic [TOTAL_W-1:0]  total;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	// predicted matcher state
	logic [SYM_W-1:0]      pat_bytes [MAX_PATTERN];
	logic [LEN_W-1:0]      fail_len  [MAX_PATTERN];
	int                    pat_len;
	int                    build_len;
	int                    partial_len;
	logic [COUNT_BITS-1:0] hits;
	int                    errs;

	// results owed by the block, oldest first
	outcome_t awaited [$];

	assign mismatches = errs;

	// apply one command to the predicted state and return the result it owes
	function automatic outcome_t step_matcher(input logic [CMD_W-1:0] op,
			input logic [SYM_W-1:0] sym);
		outcome_t res;
		int       j;
		res.hit    = 1'b0;
		res.status = STATUS_OK;
		case (op)
			CMD_CLEAR: begin
				pat_len     = 0;
				build_len   = 0;
				partial_len = 0;
				hits        = '0;
			end
			CMD_APPEND: begin
				if (pat_len >= MAX_PATTERN) begin
					res.status = STATUS_FULL;
				end else begin
					// extend the prefix function by one entry
					j = 0;
					if (pat_len > 0) begin
						j = build_len;
						while (j > 0 && sym != pat_bytes[j])
							j = int'(fail_len[j-1]);
						if (sym == pat_bytes[j])
							j++;
					end
					pat_bytes[pat_len] = sym;
					fail_len[pat_len]  = LEN_W'(j);
					build_len          = j;
					pat_len++;
				end
			end
			CMD_TEXT: begin
				if (pat_len == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					// follow failure links until the byte extends the partial match
					j = partial_len;
					while (j > 0 && sym != pat_bytes[j])
						j = int'(fail_len[j-1]);
					if (j < pat_len && sym == pat_bytes[j])
						j++;
					// whole pattern seen: count it and fall back for overlaps
					if (j >= pat_len) begin
						res.hit = 1'b1;
						if (hits != COUNT_MAX)
							hits++;
						j = int'(fail_len[pat_len-1]);
					end
					partial_len = j;
				end
			end
			default: ;
		endcase
		res.total = hits[TOTAL_W-1:0];
		return res;
	endfunction

	// compare results as they leave, predict commands as they enter
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			pat_len     = 0;
			build_len   = 0;
			partial_len = 0;
			hits        = '0;
			errs        = 0;
			awaited.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					$error("result transfer with nothing pending: match_total %0d", m_tdata);
					errs++;
				end else begin
					want = awaited.pop_front();
					if (m_tuser[0] !== want.hit) begin
						$error("match: expected %0d, got %0d", want.hit, m_tuser[0]);
						errs++;
					end
					if (m_tdata !== want.total) begin
						$error("match_total: expected %0d, got %0d", want.total, m_tdata);
						errs++;
					end
					if (m_tuser[2:1] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited.insert(awaited.size(), step_matcher(s_tuser, s_tdata));
			outstanding <= awaited.size();
		end
	end

endmodule

/* tb/tb.sv */
// top of the occurrence counter testbench: clock, reset, command stimulus and verdict
// depends on kmpoc_pkg, kmp_occurrence_counter and kmpoc_checker

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kmpoc_pkg::*;

	// unused command code: the block must answer it without any change of state
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int TOTAL_ITEMS = 1625;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	int mismatches;
	int outstanding;
	int fed;
	int cycles;
	bit calm;

	always #5 clk = ~clk;

	kmp_occurrence_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	kmpoc_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// idle length: mostly none, some short, a few long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// one command transfer, with an optional gap in front
	task automatic feed(input logic [CMD_W-1:0] op, input logic [SYM_W-1:0] sym);
		int gap;
		gap = calm ? 0 : idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= sym;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op != CMD_UNUSED)
			fed++;
	endtask

	// hold off the sender until every owed result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// receiver back-pressure
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (calm || stall == 0) begin
				m_tready <= 1'b1;
				if (!calm)
					stall = idle_cycles();
			end else begin
				m_tready <= 1'b0;
				stall--;
			end
		end
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [SYM_W-1:0] alph  [3];
		logic [SYM_W-1:0] motif [4];
		int n_alph, mlen, plen, tlen, seq, r;
		calm = 1'b0;
		fed  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pattern, unused code, overlaps, append mid-match, clear
		feed(CMD_TEXT, 8'h00);
		feed(CMD_UNUSED, 8'hff);
		feed(CMD_APPEND, 8'h00);
		feed(CMD_APPEND, 8'h00);
		feed(CMD_TEXT, 8'h00);
		feed(CMD_TEXT, 8'h00);
		feed(CMD_TEXT, 8'h00);
		feed(CMD_TEXT, 8'hff);
		feed(CMD_TEXT, 8'h00);
		feed(CMD_TEXT, 8'h00);
		feed(CMD_APPEND, 8'hff);
		feed(CMD_TEXT, 8'h00);
		feed(CMD_TEXT, 8'hff);
		feed(CMD_UNUSED, 8'h00);
		feed(CMD_CLEAR, 8'ha5);
		feed(CMD_TEXT, 8'hff);
		feed(CMD_APPEND, 8'hff);
		feed(CMD_TEXT, 8'hff);
		feed(CMD_TEXT, 8'hff);
		feed(CMD_TEXT, 8'h7e);
		feed(CMD_CLEAR, 8'h00);

		// random runs: short patterns over small alphabets, then text with some noise
		seq = 0;
		while (fed < TOTAL_ITEMS) begin
			calm   = ($urandom_range(0, 3) == 0);
			n_alph = $urandom_range(1, 3);
			foreach (alph[k])
				alph[k] = SYM_W'($urandom_range(0, 255));
			if (seq == 2) begin
				// fill the whole store with a repeated motif, overflow it, then scan
				mlen = $urandom_range(1, 4);
				foreach (motif[k])
					motif[k] = alph[$urandom_range(0, n_alph - 1)];
				feed(CMD_CLEAR, SYM_W'($urandom_range(0, 255)));
				for (int k = 0; k < MAX_PATTERN + 3; k++)
					feed(CMD_APPEND, motif[k % mlen]);
				for (int k = 0; k < 300; k++) begin
					if ($urandom_range(0, 19) == 0)
						feed(CMD_TEXT, alph[$urandom_range(0, n_alph - 1)]);
					else
						feed(CMD_TEXT, motif[k % mlen]);
				end
			end else begin
				if ($urandom_range(0, 4) != 0)
					feed(CMD_CLEAR, SYM_W'($urandom_range(0, 255)));
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				for (int k = 0; k < plen; k++)
					feed(CMD_APPEND, alph[$urandom_range(0, n_alph - 1)]);
				tlen = $urandom_range(10, 60);
				for (int k = 0; k < tlen; k++) begin
					r = $urandom_range(0, 99);
					if (r < 90)
						feed(CMD_TEXT, alph[$urandom_range(0, n_alph - 1)]);
					else if (r < 95)
						feed(CMD_TEXT, SYM_W'($urandom_range(0, 255)));
					else if (r < 97)
						feed(CMD_UNUSED, SYM_W'($urandom_range(0, 255)));
					else if (r < 99)
						feed(CMD_APPEND, alph[$urandom_range(0, n_alph - 1)]);
					else
						feed(CMD_CLEAR, SYM_W'($urandom_range(0, 255)));
				end
			end
			if (seq == 1 || $urandom_range(0, 9) == 0)
				drain();
			seq++;
		end

		// wait for the last results, then a short tail
		calm = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
